[rtl/core/owo_pkg.sv]
// ----------------------------------------------------------------------------
// owo_pkg
// Shared constants, sequencer states and the sine table generator of the
// omni wheel odometry unit.
// ----------------------------------------------------------------------------
package owo_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SINE_BITS_DEF   = 16;
  localparam int ACC_WIDTH_DEF   = 48;

  localparam int DATA_W    = 32;
  localparam int MUL_W     = DATA_W + 1;
  localparam int HEAD_W    = 9;
  localparam int STEP_W    = 4;
  localparam int SINE_LAST = 90;
  localparam int IDX_W     = 7;
  localparam int NUM_WHEEL = 4;

  localparam logic [STEP_W-1:0] PROJ_LAST = STEP_W'(2 * NUM_WHEEL);
  localparam logic [DATA_W-1:0] MPP_RESET = 32'd351383;

  // Pi in Q2.30, the base of the table generator.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROJ,
    ST_SAT,
    ST_MAG,
    ST_SCALE,
    ST_FINAL
  } owo_state_t;

  // Sine of k degrees in Q2.30 from a nine-term Taylor series.
  // Evaluated only at elaboration to fill the constant table.
  function automatic logic [63:0] sine_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    return sum;
  endfunction

  // Table entry rounded to frac fraction bits, clipped below one.
  function automatic logic [63:0] sine_entry(input int unsigned k,
                                             input int unsigned frac);
    logic [63:0] v;
    logic [63:0] lim;
    v   = (sine_q30(k) + (64'd1 << (29 - frac))) >> (30 - frac);
    lim = (64'd1 << frac) - 64'd1;
    return (v > lim) ? lim : v;
  endfunction

endpackage

[rtl/core/omni_wheel_odometry_unit.sv]
// ----------------------------------------------------------------------------
// omni_wheel_odometry_unit
// Four wheel omni odometry: encoder deltas projected through a degree sine
// table, saturating X/Y accumulators and scaling to Q16.16 metres.
// ----------------------------------------------------------------------------
// A request passes the projection and accumulate states, then the magnitude,
// scaling and final states for X and again for Y, before it reaches the
// output register; one item is in work at a time, and in_stall holds off new
// requests until then. The single shared 33 x 33 multiplier serves all
// projection and scaling products. Reset (rst_n low, synchronous) clears the
// stored counts and accumulators and loads metres_per_pulse with 351383.
module omni_wheel_odometry_unit
  import owo_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int SINE_BITS   = SINE_BITS_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_wheel1_count,
  input  logic signed [DATA_W-1:0] in_wheel2_count,
  input  logic signed [DATA_W-1:0] in_wheel3_count,
  input  logic signed [DATA_W-1:0] in_wheel4_count,
  input  logic        [HEAD_W-1:0] in_heading_deg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_pos_x,
  output logic signed [DATA_W-1:0] out_pos_y,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic        [DATA_W-1:0] cfg_metres_per_pulse
);

  localparam int SUM_W     = COUNT_WIDTH + SINE_BITS + 2;
  localparam int T_W       = ((ACC_WIDTH > SUM_W) ? ACC_WIDTH : SUM_W) + 1;
  localparam int NCH       = (ACC_WIDTH + DATA_W - 1) / DATA_W;
  localparam int CHI_W     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MAG_PAD_W = NCH * DATA_W;
  localparam int PACC_W    = ACC_WIDTH + DATA_W + 1;
  localparam int SH        = SINE_BITS - 1 + 16;
  localparam int Q_W       = PACC_W - SH;

  localparam logic signed [T_W-1:0] AccMax = T_W'({1'b0, {(ACC_WIDTH - 1){1'b1}}});
  localparam logic signed [T_W-1:0] AccMin = -AccMax - T_W'(1);
  localparam logic [PACC_W-1:0]     RoundK = PACC_W'(1) << (SH - 1);
  localparam logic [STEP_W-1:0]     ScaleLast = STEP_W'(NCH);

  // Constant sine table, one entry per degree of the first quadrant.
  logic [SINE_BITS-2:0] sine_tbl [0:SINE_LAST];

  for (genvar gk = 0; gk <= SINE_LAST; gk++) begin : g_rom
    localparam logic [63:0] EntryVal = sine_entry(gk, SINE_BITS - 1);
    assign sine_tbl[gk] = EntryVal[SINE_BITS-2:0];
  end

  owo_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic              axis_r;

  logic        [COUNT_WIDTH-1:0] prev_r  [NUM_WHEEL];
  logic signed [COUNT_WIDTH-1:0] delta_r [NUM_WHEEL];
  logic        [HEAD_W-1:0]      ang_r;
  logic signed [SUM_W-1:0]       sx_r, sy_r;
  logic signed [ACC_WIDTH-1:0]   x_acc_r, y_acc_r;
  logic        [ACC_WIDTH-1:0]   mag_r;
  logic                          neg_r;
  logic        [PACC_W-1:0]      pacc_r;
  logic signed [2*MUL_W-1:0]     prod_r;
  logic        [DATA_W-1:0]      mpp_r;
  logic signed [DATA_W-1:0]      res_x_r;
  logic signed [DATA_W-1:0]      out_pos_x_r, out_pos_y_r;
  logic                          out_valid_r;

  logic out_busy;
  logic accept, proj_add, sat_en, mag_en, scale_add, fin_x, fin_y;

  assign out_busy  = out_valid_r & out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PROJ;
      end
      ST_PROJ: begin
        if (step_r == PROJ_LAST) state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (step_r[0]) state_nxt = ST_MAG;
      end
      ST_MAG: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (step_r == ScaleLast) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (!axis_r) state_nxt = ST_MAG;
        else if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control decode.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    accept    = 1'b0;
    proj_add  = 1'b0;
    sat_en    = 1'b0;
    mag_en    = 1'b0;
    scale_add = 1'b0;
    fin_x     = 1'b0;
    fin_y     = 1'b0;
    case (state_r)
      ST_IDLE:  accept    = in_valid;
      ST_PROJ:  proj_add  = (step_r != '0);
      ST_SAT:   sat_en    = 1'b1;
      ST_MAG:   mag_en    = 1'b1;
      ST_SCALE: scale_add = (step_r != '0);
      ST_FINAL: begin
        fin_x = ~axis_r;
        fin_y = axis_r & ~out_busy;
      end
      default: ;
    endcase
  end

  // Angle handling and table lookup for the current projection step.
  logic [HEAD_W-1:0]      ang_cos, ang_sel;
  logic [IDX_W-1:0]       tbl_idx;
  logic                   tbl_neg, coef_neg;
  logic [SINE_BITS-2:0]   sine_mag;
  logic signed [SINE_BITS-1:0] coef;

  always_comb begin
    ang_cos = (ang_r >= 9'd270) ? ang_r - 9'd270 : ang_r + 9'd90;
    ang_sel = step_r[0] ? ang_cos : ang_r;
    if (ang_sel <= 9'd90) begin
      tbl_idx = ang_sel[IDX_W-1:0];
      tbl_neg = 1'b0;
    end else if (ang_sel <= 9'd180) begin
      tbl_idx = IDX_W'(9'd180 - ang_sel);
      tbl_neg = 1'b0;
    end else if (ang_sel <= 9'd270) begin
      tbl_idx = IDX_W'(ang_sel - 9'd180);
      tbl_neg = 1'b1;
    end else begin
      tbl_idx = IDX_W'(9'd360 - ang_sel);
      tbl_neg = 1'b1;
    end
    sine_mag = sine_tbl[tbl_idx];
    // The X axis takes minus the sine, the Y axis the cosine.
    coef_neg = step_r[0] ? tbl_neg : ~tbl_neg;
    coef     = coef_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  end

  // Shared multiplier operands.
  logic [MAG_PAD_W-1:0]        mag_pad;
  logic [CHI_W-1:0]            chunk_idx, pchunk;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [2*MUL_W-1:0]   mul_p;

  always_comb begin
    mag_pad   = MAG_PAD_W'(mag_r);
    chunk_idx = step_r[CHI_W-1:0];
    pchunk    = CHI_W'(step_r - STEP_W'(1));
    if (state_r == ST_PROJ) begin
      mul_a = MUL_W'(delta_r[step_r[2:1]]);
      mul_b = MUL_W'(coef);
    end else begin
      mul_a = $signed({1'b0, mag_pad[chunk_idx*DATA_W +: DATA_W]});
      mul_b = $signed({1'b0, mpp_r});
    end
    mul_p = mul_a * mul_b;
  end

  // Saturating accumulate, magnitude and final rounding/saturation.
  logic signed [ACC_WIDTH-1:0] sat_acc, mag_src, sat_res;
  logic signed [SUM_W-1:0]     sat_s;
  logic signed [T_W-1:0]       sat_sum;
  logic [Q_W-1:0]              q, qlim;
  logic [DATA_W-1:0]           qc;
  logic signed [DATA_W-1:0]    res;
  logic [COUNT_WIDTH-1:0]      cnt_in [NUM_WHEEL];
  logic [HEAD_W-1:0]           hw, a0;

  always_comb begin
    sat_acc = step_r[0] ? y_acc_r : x_acc_r;
    sat_s   = step_r[0] ? sy_r : sx_r;
    sat_sum = T_W'(sat_acc) + T_W'(sat_s);
    if (sat_sum > AccMax) sat_res = AccMax[ACC_WIDTH-1:0];
    else if (sat_sum < AccMin) sat_res = AccMin[ACC_WIDTH-1:0];
    else sat_res = sat_sum[ACC_WIDTH-1:0];

    mag_src = axis_r ? y_acc_r : x_acc_r;

    q    = pacc_r[PACC_W-1:SH];
    qlim = neg_r ? Q_W'(32'h8000_0000) : Q_W'(32'h7FFF_FFFF);
    qc   = (q > qlim) ? qlim[DATA_W-1:0] : q[DATA_W-1:0];
    res  = neg_r ? -$signed(qc) : $signed(qc);

    cnt_in[0] = in_wheel1_count[COUNT_WIDTH-1:0];
    cnt_in[1] = in_wheel2_count[COUNT_WIDTH-1:0];
    cnt_in[2] = in_wheel3_count[COUNT_WIDTH-1:0];
    cnt_in[3] = in_wheel4_count[COUNT_WIDTH-1:0];
    hw = (in_heading_deg >= 9'd360) ? in_heading_deg - 9'd360 : in_heading_deg;
    a0 = hw + 9'd45;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mpp_r       <= MPP_RESET;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      for (int i = 0; i < NUM_WHEEL; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? '0 : step_r + STEP_W'(1);
      if (cfg_valid && cfg_ready) mpp_r <= cfg_metres_per_pulse;
      if (accept) begin
        axis_r <= 1'b0;
        for (int i = 0; i < NUM_WHEEL; i++) begin
          prev_r[i] <= cnt_in[i];
        end
      end
      if (fin_x) axis_r <= 1'b1;
      if (sat_en) begin
        if (step_r[0]) y_acc_r <= sat_res;
        else x_acc_r <= sat_res;
      end
      if (fin_y) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (accept) begin
      for (int i = 0; i < NUM_WHEEL; i++) begin
        delta_r[i] <= $signed(cnt_in[i] - prev_r[i]);
      end
      ang_r <= (a0 >= 9'd360) ? a0 - 9'd360 : a0;
      sx_r  <= '0;
      sy_r  <= '0;
    end
    if (state_r == ST_PROJ && step_r[0] && step_r != PROJ_LAST) ang_r <= ang_cos;
    // The product registered last cycle belongs to the previous step.
    if (proj_add) begin
      if (step_r[0]) sx_r <= sx_r + $signed(prod_r[SUM_W-1:0]);
      else sy_r <= sy_r + $signed(prod_r[SUM_W-1:0]);
    end
    if (mag_en) begin
      neg_r  <= mag_src[ACC_WIDTH-1];
      mag_r  <= mag_src[ACC_WIDTH-1] ? ACC_WIDTH'(-mag_src) : ACC_WIDTH'(mag_src);
      pacc_r <= RoundK;
    end
    if (scale_add) begin
      pacc_r <= pacc_r + (PACC_W'(prod_r[2*DATA_W-1:0]) << (pchunk * DATA_W));
    end
    if (fin_x) res_x_r <= res;
    if (fin_y) begin
      out_pos_x_r <= res_x_r;
      out_pos_y_r <= res;
    end
  end

endmodule
